### hw/rtl/pgbs_pkg.sv
// ----------------------------------------------------------------------------
// pgbs_pkg: shared types and constants for the proposal gate and best select
// Register indexes, gate reason codes, shield outcomes and selection modes.
// ----------------------------------------------------------------------------
`default_nettype none

package pgbs_pkg;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_MIN_CONFIDENCE = 3'd0,
        CFG_MAX_STATE_UNC  = 3'd1,
        CFG_MAX_ACTION_UNC = 3'd2,
        CFG_MAX_OBS_AGE    = 3'd3,
        CFG_MAX_LATENCY    = 3'd4,
        CFG_SELECTION_MODE = 3'd5,
        CFG_BATCH_LIMIT    = 3'd6
    } cfg_index_t;

    // Gate reason codes
    typedef enum logic [2:0] {
        REASON_ACCEPTED   = 3'd0,
        REASON_REPAIRED   = 3'd1,
        REASON_LOW_CONF   = 3'd2,
        REASON_STATE_UNC  = 3'd3,
        REASON_ACTION_UNC = 3'd4,
        REASON_OLD        = 3'd5,
        REASON_LATENCY    = 3'd6,
        REASON_REJECTED   = 3'd7
    } reason_t;

    // Shield outcome codes
    localparam logic [1:0] SHIELD_ACCEPT = 2'd0;
    localparam logic [1:0] SHIELD_REPAIR = 2'd1;

    // Selection modes; the remaining codes behave as lowest uncertainty
    localparam logic [1:0] MODE_ORDER = 2'd0;
    localparam logic [1:0] MODE_CONF  = 2'd1;

    // Field widths
    localparam int unsigned CONF_W  = 17;
    localparam int unsigned UNC_W   = 16;
    localparam int unsigned SUM_W   = 17;
    localparam int unsigned TIME_W  = 24;
    localparam int unsigned POS_W   = 7;
    localparam int unsigned IDX_W   = 6;
    localparam int unsigned CFG_W   = 24;
    localparam int unsigned IN_W    = 104;
    localparam int unsigned OUT_W   = 24;

    // Position counter saturates here
    localparam logic [POS_W-1:0] POS_MAX = 7'd127;

    // Index width limits the batch to this many proposals
    localparam int unsigned INDEX_SPAN = 64;

    // Reset values of the threshold registers
    localparam logic [UNC_W-1:0]  UNC_LIMIT_RST  = 16'hFFFF;
    localparam logic [TIME_W-1:0] TIME_LIMIT_RST = 24'hFFFFFF;
    localparam logic [POS_W-1:0]  BATCH_LIM_RST  = 7'd64;

    // One result item
    typedef struct packed {
        reason_t          gate_reason;
        logic             eligible;
        logic [IDX_W-1:0] item_index;
        logic             over_limit;
        logic             batch_done;
        logic             chosen_valid;
        logic [IDX_W-1:0] chosen_index;
    } result_t;

endpackage

`default_nettype wire

### hw/rtl/proposal_gate_and_best_select.sv
// ----------------------------------------------------------------------------
// proposal_gate_and_best_select
// Gates each proposal against five thresholds, keeps a running best of the
// selectable proposals and reports the chosen index at the end of a batch.
// ----------------------------------------------------------------------------
//  channel   direction  transfer when               payload
//  s_axis    in         s_tvalid & s_tready         tdata, tuser, tlast
//  m_axis    out        m_tvalid & m_tready         tdata, tlast
//  cfg       in         cfg_we                      cfg_addr, cfg_wdata
//
//  One cycle per proposal while s_tready is high: the gate, the best-so-far
//  compare and the batch counter sit between the input port and the result
//  register, and the running best loops back in the same cycle.
//  The input is taken whenever the result register is empty or being read,
//  so a stall on m_axis holds s_tready low only while a result waits.
//  Reset clears the batch state, the result valid and sets register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module proposal_gate_and_best_select #(
    parameter int unsigned MAX_BATCH = 64
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    // confidence[16:0], state_unc[32:17], action_unc[48:33],
    // obs_age[72:49], latency[96:73], zero[103:97]
    input  wire logic [pgbs_pkg::IN_W-1:0]   s_tdata,
    // shield_outcome[1:0]
    input  wire logic [1:0]                  s_tuser,
    input  wire logic                        s_tlast,
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    // gate_reason[2:0], eligible[3], item_index[9:4], over_limit[10],
    // chosen_valid[11], chosen_index[17:12], zero[23:18]
    output logic [pgbs_pkg::OUT_W-1:0]       m_tdata,
    output logic                             m_tlast,
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    input  wire logic                        cfg_we,
    input  wire logic [2:0]                  cfg_addr,
    input  wire logic [pgbs_pkg::CFG_W-1:0]  cfg_wdata
);

    localparam int unsigned POS_W = pgbs_pkg::POS_W;
    localparam int unsigned IDX_W = pgbs_pkg::IDX_W;

    // Largest usable limit: the parameter, capped by the index width
    localparam int unsigned LIMIT_CAP_I = (MAX_BATCH < pgbs_pkg::INDEX_SPAN) ?
                                          MAX_BATCH : pgbs_pkg::INDEX_SPAN;
    localparam logic [POS_W-1:0] LIMIT_CAP = POS_W'(LIMIT_CAP_I);

    // Configuration registers
    logic [pgbs_pkg::CONF_W-1:0] min_conf_reg;
    logic [pgbs_pkg::UNC_W-1:0]  max_state_unc_reg;
    logic [pgbs_pkg::UNC_W-1:0]  max_action_unc_reg;
    logic [pgbs_pkg::TIME_W-1:0] max_obs_age_reg;
    logic [pgbs_pkg::TIME_W-1:0] max_latency_reg;
    logic [1:0]                  mode_reg;
    logic [POS_W-1:0]            batch_limit_reg;

    // Batch state
    logic [POS_W-1:0]            next_index_reg, next_index_next;
    logic                        best_valid_reg, best_valid_next;
    logic [IDX_W-1:0]            best_index_reg, best_index_next;
    logic                        best_acc_reg, best_acc_next;
    logic [pgbs_pkg::CONF_W-1:0] best_conf_reg, best_conf_next;
    logic [pgbs_pkg::SUM_W-1:0]  best_unc_reg, best_unc_next;
    logic                        overflowed_reg, overflowed_next;

    // Result register
    logic                        out_valid_reg;
    pgbs_pkg::result_t           result_reg, result_next;

    // Input fields
    logic [pgbs_pkg::CONF_W-1:0] in_conf;
    logic [pgbs_pkg::UNC_W-1:0]  in_su;
    logic [pgbs_pkg::UNC_W-1:0]  in_au;
    logic [pgbs_pkg::TIME_W-1:0] in_age;
    logic [pgbs_pkg::TIME_W-1:0] in_lat;
    logic [pgbs_pkg::SUM_W-1:0]  in_unc;

    logic                        in_fire;
    logic [POS_W-1:0]            eff_limit;
    logic                        ovf_now;
    pgbs_pkg::reason_t           reason;
    logic                        elig;
    logic                        selectable;
    logic                        acc;
    logic                        conf_gt, conf_eq, unc_lt, unc_eq;
    logic                        beats;
    logic                        take;

    assign in_conf = s_tdata[16:0];
    assign in_su   = s_tdata[32:17];
    assign in_au   = s_tdata[48:33];
    assign in_age  = s_tdata[72:49];
    assign in_lat  = s_tdata[96:73];
    assign in_unc  = {1'b0, in_su} + {1'b0, in_au};

    // Take a new item when the result register is free or being drained
    assign s_tready = !out_valid_reg || m_tready;
    assign in_fire  = s_tvalid && s_tready;

    // Clamp the batch limit into 1 .. cap
    always_comb
    begin
        if (batch_limit_reg == '0)
        begin
            eff_limit = POS_W'(1);
        end
        else if (batch_limit_reg > LIMIT_CAP)
        begin
            eff_limit = LIMIT_CAP;
        end
        else
        begin
            eff_limit = batch_limit_reg;
        end
    end

    // Gate thresholds in priority order
    always_comb
    begin
        elig = 1'b0;
        if (in_conf < min_conf_reg)
        begin
            reason = pgbs_pkg::REASON_LOW_CONF;
        end
        else if (in_su > max_state_unc_reg)
        begin
            reason = pgbs_pkg::REASON_STATE_UNC;
        end
        else if (in_au > max_action_unc_reg)
        begin
            reason = pgbs_pkg::REASON_ACTION_UNC;
        end
        else if (in_age > max_obs_age_reg)
        begin
            reason = pgbs_pkg::REASON_OLD;
        end
        else if (in_lat > max_latency_reg)
        begin
            reason = pgbs_pkg::REASON_LATENCY;
        end
        else
        begin
            elig = 1'b1;
            if (s_tuser == pgbs_pkg::SHIELD_ACCEPT)
            begin
                reason = pgbs_pkg::REASON_ACCEPTED;
            end
            else if (s_tuser == pgbs_pkg::SHIELD_REPAIR)
            begin
                reason = pgbs_pkg::REASON_REPAIRED;
            end
            else
            begin
                reason = pgbs_pkg::REASON_REJECTED;
            end
        end
    end

    assign ovf_now    = overflowed_reg || (next_index_reg >= eff_limit);
    assign acc        = (reason == pgbs_pkg::REASON_ACCEPTED);
    assign selectable = elig && (reason != pgbs_pkg::REASON_REJECTED) && !ovf_now;

    // Compare against the running best
    assign conf_gt = in_conf > best_conf_reg;
    assign conf_eq = in_conf == best_conf_reg;
    assign unc_lt  = in_unc < best_unc_reg;
    assign unc_eq  = in_unc == best_unc_reg;

    always_comb
    begin
        if (acc != best_acc_reg)
        begin
            beats = acc;
        end
        else
        begin
            case (mode_reg)
                pgbs_pkg::MODE_ORDER: beats = 1'b0;
                pgbs_pkg::MODE_CONF:  beats = conf_gt || (conf_eq && unc_lt);
                default:              beats = unc_lt || (unc_eq && conf_gt);
            endcase
        end
    end

    assign take = selectable && (!best_valid_reg || beats);

    // Next batch state and result
    always_comb
    begin
        best_valid_next = best_valid_reg;
        best_index_next = best_index_reg;
        best_acc_next   = best_acc_reg;
        best_conf_next  = best_conf_reg;
        best_unc_next   = best_unc_reg;
        overflowed_next = ovf_now;
        next_index_next = next_index_reg;

        if (take)
        begin
            best_valid_next = 1'b1;
            best_index_next = next_index_reg[IDX_W-1:0];
            best_acc_next   = acc;
            best_conf_next  = in_conf;
            best_unc_next   = in_unc;
        end

        result_next.gate_reason  = reason;
        result_next.eligible     = elig;
        result_next.item_index   = next_index_reg[IDX_W-1:0];
        result_next.over_limit   = ovf_now;
        result_next.batch_done   = s_tlast;
        result_next.chosen_valid = 1'b0;
        result_next.chosen_index = '0;

        if (s_tlast)
        begin
            if (best_valid_next && !ovf_now)
            begin
                result_next.chosen_valid = 1'b1;
                result_next.chosen_index = best_index_next;
            end
            best_valid_next = 1'b0;
            best_index_next = '0;
            best_acc_next   = 1'b0;
            best_conf_next  = '0;
            best_unc_next   = '0;
            overflowed_next = 1'b0;
            next_index_next = '0;
        end
        else if (next_index_reg < pgbs_pkg::POS_MAX)
        begin
            next_index_next = next_index_reg + POS_W'(1);
        end
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_conf_reg       <= '0;
            max_state_unc_reg  <= pgbs_pkg::UNC_LIMIT_RST;
            max_action_unc_reg <= pgbs_pkg::UNC_LIMIT_RST;
            max_obs_age_reg    <= pgbs_pkg::TIME_LIMIT_RST;
            max_latency_reg    <= pgbs_pkg::TIME_LIMIT_RST;
            mode_reg           <= pgbs_pkg::MODE_ORDER;
            batch_limit_reg    <= pgbs_pkg::BATCH_LIM_RST;
        end
        else if (cfg_we)
        begin
            case (pgbs_pkg::cfg_index_t'(cfg_addr))
                pgbs_pkg::CFG_MIN_CONFIDENCE: min_conf_reg       <= cfg_wdata[16:0];
                pgbs_pkg::CFG_MAX_STATE_UNC:  max_state_unc_reg  <= cfg_wdata[15:0];
                pgbs_pkg::CFG_MAX_ACTION_UNC: max_action_unc_reg <= cfg_wdata[15:0];
                pgbs_pkg::CFG_MAX_OBS_AGE:    max_obs_age_reg    <= cfg_wdata[23:0];
                pgbs_pkg::CFG_MAX_LATENCY:    max_latency_reg    <= cfg_wdata[23:0];
                pgbs_pkg::CFG_SELECTION_MODE: mode_reg           <= cfg_wdata[1:0];
                pgbs_pkg::CFG_BATCH_LIMIT:    batch_limit_reg    <= cfg_wdata[6:0];
                default:                      ;
            endcase
        end
    end

    // Advance batch state on each input transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            next_index_reg <= '0;
            best_valid_reg <= 1'b0;
            best_index_reg <= '0;
            best_acc_reg   <= 1'b0;
            best_conf_reg  <= '0;
            best_unc_reg   <= '0;
            overflowed_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            next_index_reg <= next_index_next;
            best_valid_reg <= best_valid_next;
            best_index_reg <= best_index_next;
            best_acc_reg   <= best_acc_next;
            best_conf_reg  <= best_conf_next;
            best_unc_reg   <= best_unc_next;
            overflowed_reg <= overflowed_next;
        end
    end

    // Result valid: set on input transfer, drop when taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Hold the result payload until the next input transfer
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            result_reg <= result_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = result_reg.batch_done;
    assign m_tdata  = {6'd0,
                       result_reg.chosen_index,
                       result_reg.chosen_valid,
                       result_reg.over_limit,
                       result_reg.item_index,
                       result_reg.eligible,
                       result_reg.gate_reason};

    // A closing proposal always starts the next batch at position zero
    a_batch_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && s_tlast) |=> (next_index_reg == '0 && !best_valid_reg
                                  && !overflowed_reg))
        else $error("batch state not cleared after last proposal");

    // A chosen index only appears on the closing result
    a_chosen_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && result_reg.chosen_valid) |-> result_reg.batch_done)
        else $error("chosen index reported before batch end");

    // An overflowed batch never reports a choice
    a_refused_batch: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && result_reg.over_limit) |-> !result_reg.chosen_valid)
        else $error("choice reported for an overflowed batch");

    // Overflow stays set until the batch closes
    a_overflow_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && overflowed_reg && !s_tlast) |=> overflowed_reg)
        else $error("overflow flag dropped inside a batch");

endmodule

`default_nettype wire

### sim/tb_proposal_gate_and_best_select.sv
// ----------------------------------------------------------------------------
// tb_proposal_gate_and_best_select: regression for the proposal gate
// Drives proposals over the stream input and predicts each verdict in a
// behavioural model kept inside the bench: the five threshold gates, the
// running best under every selection mode and the batch limit. Each
// verdict on the stream output is checked field by field. Directed cases
// come first, then batch-limit cases, then random batches under several
// register settings and idle patterns, and a long output hold-off at the end.
// ----------------------------------------------------------------------------
module tb_proposal_gate_and_best_select;

    import pgbs_pkg::*;

    localparam int unsigned MAX_BATCH    = 64;
    localparam int unsigned QUIET_LIMIT  = 2000;
    localparam int unsigned PRINT_LIMIT  = 40;
    localparam int unsigned PHASE_ITEMS  = 112;

    // Codes the package leaves unnamed
    localparam logic [1:0] SHIELD_REJECT = 2'd2;
    localparam logic [1:0] SHIELD_SPARE  = 2'd3;
    localparam logic [1:0] MODE_UNC      = 2'd2;
    localparam logic [1:0] MODE_SPARE    = 2'd3;
    localparam logic [2:0] CFG_UNUSED    = 3'd7;

    typedef struct packed {
        logic [CONF_W-1:0] confidence;
        logic [UNC_W-1:0]  state_unc;
        logic [UNC_W-1:0]  action_unc;
        logic [TIME_W-1:0] obs_age;
        logic [TIME_W-1:0] latency;
        logic [1:0]        shield;
        logic              ends_batch;
    } proposal_t;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic [IN_W-1:0]   s_tdata   = '0;
    logic [1:0]        s_tuser   = '0;
    logic              s_tlast   = 1'b0;
    logic              s_tvalid  = 1'b0;
    logic              s_tready;
    logic [OUT_W-1:0]  m_tdata;
    logic              m_tlast;
    logic              m_tvalid;
    logic              m_tready  = 1'b0;
    logic              cfg_we    = 1'b0;
    logic [2:0]        cfg_addr  = '0;
    logic [CFG_W-1:0]  cfg_wdata = '0;

    // Register mirror
    logic [CONF_W-1:0] lim_conf  = '0;
    logic [UNC_W-1:0]  lim_su    = UNC_LIMIT_RST;
    logic [UNC_W-1:0]  lim_au    = UNC_LIMIT_RST;
    logic [TIME_W-1:0] lim_age   = TIME_LIMIT_RST;
    logic [TIME_W-1:0] lim_lat   = TIME_LIMIT_RST;
    logic [1:0]        sel_mode  = MODE_ORDER;
    logic [POS_W-1:0]  batch_cap = BATCH_LIM_RST;

    // Batch state mirror
    logic [POS_W-1:0]  next_pos       = '0;
    logic              best_valid     = 1'b0;
    logic [IDX_W-1:0]  best_idx       = '0;
    logic              best_accept    = 1'b0;
    logic [CONF_W-1:0] best_conf      = '0;
    logic [SUM_W-1:0]  best_unc       = '0;
    logic              batch_overflow = 1'b0;

    result_t     due_verdicts[$];
    result_t     verdict_want;
    int unsigned mismatch_count = 0;
    int unsigned results_seen   = 0;
    int unsigned quiet_cycles   = 0;
    int unsigned src_idle_pct   = 0;
    int unsigned sink_stall_pct = 0;
    logic        sink_hold      = 1'b0;

    proposal_t   batch_q[$];

    proposal_gate_and_best_select #(
        .MAX_BATCH (MAX_BATCH)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Behavioural model
    // ------------------------------------------------------------------

    // Batch limit after clamping to 1..MAX_BATCH and to the index span
    function automatic int unsigned cap_in_force();
        int unsigned lim;
        lim = batch_cap;
        if (lim < 1)
            lim = 1;
        if (lim > MAX_BATCH)
            lim = MAX_BATCH;
        if (lim > INDEX_SPAN)
            lim = INDEX_SPAN;
        return lim;
    endfunction

    // True when a later candidate displaces the running best
    function automatic bit displaces_best(input logic acc, input logic [CONF_W-1:0] conf,
                                          input logic [SUM_W-1:0] unc);
        if (acc != best_accept)
            return acc;
        if (sel_mode == MODE_ORDER)
            return 1'b0;
        if (sel_mode == MODE_CONF)
        begin
            if (conf != best_conf)
                return conf > best_conf;
            return unc < best_unc;
        end
        if (unc != best_unc)
            return unc < best_unc;
        return conf > best_conf;
    endfunction

    // Gate one proposal, update the running best and form its verdict
    function automatic result_t judge_proposal(input proposal_t p);
        result_t          v;
        logic [SUM_W-1:0] unc;
        logic             passed;
        reason_t          why;
        unc    = SUM_W'(p.state_unc) + SUM_W'(p.action_unc);
        passed = 1'b0;
        if (p.confidence < lim_conf)
            why = REASON_LOW_CONF;
        else if (p.state_unc > lim_su)
            why = REASON_STATE_UNC;
        else if (p.action_unc > lim_au)
            why = REASON_ACTION_UNC;
        else if (p.obs_age > lim_age)
            why = REASON_OLD;
        else if (p.latency > lim_lat)
            why = REASON_LATENCY;
        else
        begin
            passed = 1'b1;
            if (p.shield == SHIELD_ACCEPT)
                why = REASON_ACCEPTED;
            else if (p.shield == SHIELD_REPAIR)
                why = REASON_REPAIRED;
            else
                why = REASON_REJECTED;
        end

        if (next_pos >= cap_in_force())
            batch_overflow = 1'b1;

        if (passed && why != REASON_REJECTED && !batch_overflow)
        begin
            if (!best_valid || displaces_best(why == REASON_ACCEPTED, p.confidence, unc))
            begin
                best_valid  = 1'b1;
                best_idx    = next_pos[IDX_W-1:0];
                best_accept = (why == REASON_ACCEPTED);
                best_conf   = p.confidence;
                best_unc    = unc;
            end
        end

        v.gate_reason  = why;
        v.eligible     = passed;
        v.item_index   = next_pos[IDX_W-1:0];
        v.over_limit   = batch_overflow;
        v.batch_done   = p.ends_batch;
        v.chosen_valid = 1'b0;
        v.chosen_index = '0;

        // Report the winner and open a new batch, or advance the position
        if (p.ends_batch)
        begin
            if (best_valid && !batch_overflow)
            begin
                v.chosen_valid = 1'b1;
                v.chosen_index = best_idx;
            end
            next_pos       = '0;
            best_valid     = 1'b0;
            best_idx       = '0;
            best_accept    = 1'b0;
            best_conf      = '0;
            best_unc       = '0;
            batch_overflow = 1'b0;
        end
        else if (next_pos != POS_MAX)
            next_pos = next_pos + 1'b1;
        return v;
    endfunction

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------

    task automatic flag_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
            $display("ERROR: %s", what);
    endtask

    task automatic check_field(input string name, input int unsigned got,
                               input int unsigned want);
        if (got != want)
            flag_mismatch($sformatf("verdict %0d %s: got %0d, expected %0d",
                                    results_seen, name, got, want));
    endtask

    // Compare each transfer on the output with the oldest predicted verdict
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (due_verdicts.size() == 0)
                flag_mismatch($sformatf("verdict %0d arrived with no proposal outstanding",
                                        results_seen));
            else
            begin
                verdict_want = due_verdicts.pop_front();
                check_field("gate_reason",  m_tdata[2:0],   verdict_want.gate_reason);
                check_field("eligible",     m_tdata[3],     verdict_want.eligible);
                check_field("item_index",   m_tdata[9:4],   verdict_want.item_index);
                check_field("over_limit",   m_tdata[10],    verdict_want.over_limit);
                check_field("batch_done",   m_tlast,        verdict_want.batch_done);
                check_field("chosen_valid", m_tdata[11],    verdict_want.chosen_valid);
                check_field("chosen_index", m_tdata[17:12], verdict_want.chosen_index);
            end
            results_seen++;
        end
    end

    // Output readiness: random stalls, held low during a hold-off
    always @(posedge clk)
    begin
        if (rst_n)
            m_tready <= !sink_hold && ($urandom_range(99) >= sink_stall_pct);
    end

    // Stop the run when no transfer happens for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic proposal_t make_proposal(input logic [CONF_W-1:0] conf,
                                                input logic [UNC_W-1:0] su,
                                                input logic [UNC_W-1:0] au,
                                                input logic [TIME_W-1:0] age,
                                                input logic [TIME_W-1:0] lat,
                                                input logic [1:0] shield,
                                                input logic ends_batch);
        proposal_t p;
        p.confidence = conf;
        p.state_unc  = su;
        p.action_unc = au;
        p.obs_age    = age;
        p.latency    = lat;
        p.shield     = shield;
        p.ends_batch = ends_batch;
        return p;
    endfunction

    // Append one proposal to the run being built
    function automatic void add_proposal(input proposal_t p);
        batch_q.insert(batch_q.size(), p);
    endfunction

    // Offer a run of proposals; each transfer queues its predicted verdict
    task automatic offer_items(input proposal_t items[$]);
        for (int i = 0; i < items.size(); i++)
        begin
            s_tdata  <= {7'd0, items[i].latency, items[i].obs_age, items[i].action_unc,
                         items[i].state_unc, items[i].confidence};
            s_tuser  <= items[i].shield;
            s_tlast  <= items[i].ends_batch;
            s_tvalid <= 1'b1;
            do
                @(posedge clk);
            while (!s_tready);
            due_verdicts.insert(due_verdicts.size(), judge_proposal(items[i]));
            // Drop valid after the last one, or idle for a random gap
            if (i == items.size() - 1)
                s_tvalid <= 1'b0;
            else if ($urandom_range(99) < src_idle_pct)
            begin
                s_tvalid <= 1'b0;
                do
                    @(posedge clk);
                while ($urandom_range(99) < src_idle_pct);
            end
        end
    endtask

    // Wait until every verdict is back and the block is idle
    task automatic settle_block();
        while (due_verdicts.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] addr, input logic [CFG_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= value;
        @(posedge clk);
        case (addr)
            CFG_MIN_CONFIDENCE: lim_conf  = value[CONF_W-1:0];
            CFG_MAX_STATE_UNC:  lim_su    = value[UNC_W-1:0];
            CFG_MAX_ACTION_UNC: lim_au    = value[UNC_W-1:0];
            CFG_MAX_OBS_AGE:    lim_age   = value[TIME_W-1:0];
            CFG_MAX_LATENCY:    lim_lat   = value[TIME_W-1:0];
            CFG_SELECTION_MODE: sel_mode  = value[1:0];
            CFG_BATCH_LIMIT:    batch_cap = value[POS_W-1:0];
            default: ;
        endcase
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_idling(input int unsigned src_pct, input int unsigned sink_pct);
        src_idle_pct = src_pct;
        sink_stall_pct <= sink_pct;
    endtask

    function automatic int unsigned pick_setting(input int unsigned lo, input int unsigned hi);
        case ($urandom_range(3))
            0:       return lo;
            1:       return hi;
            default: return $urandom_range(hi, lo);
        endcase
    endfunction

    // Value at or below the limit to pass, above it to fail where possible
    function automatic int unsigned draw_at_most(input int unsigned lim, input int unsigned top,
                                                 input bit pass);
        if (pass || lim >= top)
            return $urandom_range(lim, 0);
        return $urandom_range(top, lim + 1);
    endfunction

    function automatic logic [CONF_W-1:0] draw_confidence(input bit pass, input bit coarse);
        if (coarse)
            return (lim_conf == 17'h1FFFF) ? lim_conf : lim_conf + CONF_W'($urandom_range(1));
        if (pass || lim_conf == 0)
            return CONF_W'($urandom_range(17'h1FFFF, lim_conf));
        return CONF_W'($urandom_range(lim_conf - 1, 0));
    endfunction

    // Mostly gate-passing proposals; coarse values force ties in the best
    function automatic proposal_t random_proposal(input logic ends_batch);
        proposal_t   p;
        bit          coarse;
        int unsigned roll;
        coarse       = ($urandom_range(3) == 0);
        p.confidence = draw_confidence($urandom_range(99) < 90, coarse);
        p.state_unc  = coarse ? UNC_W'($urandom_range(1))
                              : UNC_W'(draw_at_most(lim_su, 16'hFFFF, $urandom_range(99) < 90));
        p.action_unc = coarse ? UNC_W'($urandom_range(1))
                              : UNC_W'(draw_at_most(lim_au, 16'hFFFF, $urandom_range(99) < 90));
        p.obs_age    = TIME_W'(draw_at_most(lim_age, 24'hFFFFFF, $urandom_range(99) < 92));
        p.latency    = TIME_W'(draw_at_most(lim_lat, 24'hFFFFFF, $urandom_range(99) < 92));
        roll = $urandom_range(9);
        if (roll < 4)
            p.shield = SHIELD_ACCEPT;
        else if (roll < 7)
            p.shield = SHIELD_REPAIR;
        else if (roll < 9)
            p.shield = SHIELD_REJECT;
        else
            p.shield = SHIELD_SPARE;
        // Occasional noise across the whole field range
        if ($urandom_range(19) == 0)
        begin
            p.confidence = CONF_W'($urandom);
            p.state_unc  = UNC_W'($urandom);
            p.action_unc = UNC_W'($urandom);
            p.obs_age    = TIME_W'($urandom);
            p.latency    = TIME_W'($urandom);
        end
        p.ends_batch = ends_batch;
        return p;
    endfunction

    // Append one whole batch; most fit the limit, some run past it
    task automatic append_batch(input int unsigned len);
        for (int unsigned i = 0; i < len; i++)
            add_proposal(random_proposal(i == len - 1));
    endtask

    function automatic int unsigned pick_batch_len();
        int unsigned lim;
        lim = cap_in_force();
        case ($urandom_range(9))
            0, 1, 2, 3, 4: return $urandom_range((lim < 8) ? lim : 8, 1);
            5, 6, 7:       return $urandom_range(lim, 1);
            8:             return lim;
            default:       return lim + $urandom_range(3, 1);
        endcase
    endfunction

    task automatic shuffle_registers();
        write_reg(CFG_MIN_CONFIDENCE, pick_setting(0, 17'h1FFFF));
        write_reg(CFG_MAX_STATE_UNC,  pick_setting(0, 16'hFFFF));
        write_reg(CFG_MAX_ACTION_UNC, pick_setting(0, 16'hFFFF));
        write_reg(CFG_MAX_OBS_AGE,    pick_setting(0, 24'hFFFFFF));
        write_reg(CFG_MAX_LATENCY,    pick_setting(0, 24'hFFFFFF));
        write_reg(CFG_SELECTION_MODE, $urandom_range(3));
        case ($urandom_range(4))
            0:       write_reg(CFG_BATCH_LIMIT, 0);
            1:       write_reg(CFG_BATCH_LIMIT, 1);
            2:       write_reg(CFG_BATCH_LIMIT, 64);
            3:       write_reg(CFG_BATCH_LIMIT, 127);
            default: write_reg(CFG_BATCH_LIMIT, $urandom_range(63, 2));
        endcase
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Field extremes, every gate reason in priority order, every mode
    task automatic test_directed_cases();
        set_idling(0, 0);

        // Reset settings: input order keeps the first of two accepts
        batch_q = {};
        add_proposal(make_proposal(0, 0, 0, 0, 0, SHIELD_ACCEPT, 1'b0));
        add_proposal(make_proposal(17'h1FFFF, 16'hFFFF, 16'hFFFF, 24'hFFFFFF,
                                   24'hFFFFFF, SHIELD_ACCEPT, 1'b1));
        offer_items(batch_q);
        settle_block();

        write_reg(CFG_MIN_CONFIDENCE, 17'h08000);
        write_reg(CFG_MAX_STATE_UNC,  16'h1000);
        write_reg(CFG_MAX_ACTION_UNC, 16'h2000);
        write_reg(CFG_MAX_OBS_AGE,    1000);
        write_reg(CFG_MAX_LATENCY,    500);
        write_reg(CFG_SELECTION_MODE, MODE_CONF);
        write_reg(CFG_UNUSED,         24'hFFFFFF);

        // Each gate just failed, with later gates failing too
        batch_q = {};
        add_proposal(make_proposal(17'h07FFF, 16'hFFFF, 16'hFFFF, 24'hFFFFFF,
                                   24'hFFFFFF, SHIELD_ACCEPT, 1'b0));
        add_proposal(make_proposal(17'h08000, 16'h1001, 16'hFFFF, 24'hFFFFFF,
                                   24'hFFFFFF, SHIELD_ACCEPT, 1'b0));
        add_proposal(make_proposal(17'h08000, 16'h1000, 16'h2001, 24'hFFFFFF,
                                   24'hFFFFFF, SHIELD_ACCEPT, 1'b0));
        add_proposal(make_proposal(17'h08000, 16'h1000, 16'h2000, 1001,
                                   24'hFFFFFF, SHIELD_ACCEPT, 1'b0));
        add_proposal(make_proposal(17'h08000, 16'h1000, 16'h2000, 1000,
                                   501, SHIELD_ACCEPT, 1'b0));
        // Shield reject and the spare shield code both reject
        add_proposal(make_proposal(17'h08000, 16'h1000, 16'h2000, 1000, 500,
                                   SHIELD_REJECT, 1'b0));
        add_proposal(make_proposal(17'h08000, 16'h1000, 16'h2000, 1000, 500,
                                   SHIELD_SPARE, 1'b0));
        // Repair first, then an accept beats it despite lower confidence
        add_proposal(make_proposal(17'h09000, 16'h0100, 16'h0100, 0, 0,
                                   SHIELD_REPAIR, 1'b0));
        add_proposal(make_proposal(17'h08000, 16'h1000, 16'h2000, 1000, 500,
                                   SHIELD_ACCEPT, 1'b0));
        // Confidence above 1.0 wins, then lower sum on equal confidence, then tie
        add_proposal(make_proposal(17'h1FFFF, 16'h0800, 16'h0800, 0, 0,
                                   SHIELD_ACCEPT, 1'b0));
        add_proposal(make_proposal(17'h1FFFF, 16'h0400, 16'h0800, 0, 0,
                                   SHIELD_ACCEPT, 1'b0));
        add_proposal(make_proposal(17'h1FFFF, 16'h0800, 16'h0400, 0, 0,
                                   SHIELD_ACCEPT, 1'b1));
        offer_items(batch_q);
        settle_block();

        // Lowest sum mode: sum decides, confidence only breaks sum ties
        write_reg(CFG_SELECTION_MODE, MODE_UNC);
        batch_q = {};
        add_proposal(make_proposal(17'h09000, 16'h0010, 16'h0010, 0, 0,
                                   SHIELD_ACCEPT, 1'b0));
        add_proposal(make_proposal(17'h08000, 16'h0010, 16'h0010, 0, 0,
                                   SHIELD_ACCEPT, 1'b0));
        add_proposal(make_proposal(17'h08001, 16'h0008, 16'h0008, 0, 0,
                                   SHIELD_REPAIR, 1'b0));
        add_proposal(make_proposal(17'h08000, 16'h0000, 16'h0000, 0, 0,
                                   SHIELD_ACCEPT, 1'b1));
        offer_items(batch_q);
        settle_block();

        // Spare mode code acts as lowest sum
        write_reg(CFG_SELECTION_MODE, MODE_SPARE);
        batch_q = {};
        add_proposal(make_proposal(17'h08000, 16'h0020, 16'h0000, 0, 0,
                                   SHIELD_ACCEPT, 1'b0));
        add_proposal(make_proposal(17'h09000, 16'h0020, 16'h0000, 0, 0,
                                   SHIELD_ACCEPT, 1'b1));
        // Batch with nothing selectable
        add_proposal(make_proposal(17'h08000, 16'h0000, 16'h0000, 0, 0,
                                   SHIELD_REJECT, 1'b0));
        add_proposal(make_proposal(17'h00000, 16'h0000, 16'h0000, 0, 0,
                                   SHIELD_ACCEPT, 1'b1));
        offer_items(batch_q);
        settle_block();
    endtask

    // Limit of zero acts as one, clamp above 64, position saturation, full batch
    task automatic test_batch_limit();
        set_idling(17, 17);
        write_reg(CFG_MIN_CONFIDENCE, 0);
        write_reg(CFG_MAX_STATE_UNC,  16'hFFFF);
        write_reg(CFG_MAX_ACTION_UNC, 16'hFFFF);
        write_reg(CFG_MAX_OBS_AGE,    24'hFFFFFF);
        write_reg(CFG_MAX_LATENCY,    24'hFFFFFF);
        write_reg(CFG_SELECTION_MODE, MODE_CONF);

        write_reg(CFG_BATCH_LIMIT, 0);
        batch_q = {};
        for (int i = 0; i < 3; i++)
            add_proposal(make_proposal(17'h10000, 0, 0, 0, 0, SHIELD_ACCEPT, i == 2));
        offer_items(batch_q);
        settle_block();

        write_reg(CFG_BATCH_LIMIT, 1);
        batch_q = {};
        add_proposal(make_proposal(17'h10000, 0, 0, 0, 0, SHIELD_REPAIR, 1'b1));
        offer_items(batch_q);
        settle_block();

        write_reg(CFG_BATCH_LIMIT, 127);
        batch_q = {};
        append_batch(130);
        offer_items(batch_q);
        settle_block();

        write_reg(CFG_BATCH_LIMIT, 64);
        batch_q = {};
        append_batch(64);
        offer_items(batch_q);
        settle_block();
    endtask

    // Random batches under fresh settings for each idle pattern
    task automatic test_random_traffic();
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph % 4)
                0:       set_idling(0, 0);
                1:       set_idling(63, 0);
                2:       set_idling(0, 63);
                default: set_idling(17, 17);
            endcase
            shuffle_registers();
            batch_q = {};
            while (batch_q.size() < PHASE_ITEMS)
                append_batch(pick_batch_len());
            offer_items(batch_q);
            settle_block();
        end
    endtask

    // Hold the output off while proposals keep coming, so the input stalls
    task automatic test_input_backpressure();
        set_idling(0, 0);
        write_reg(CFG_BATCH_LIMIT, 64);
        batch_q = {};
        append_batch(20);
        append_batch(10);
        fork
            begin
                sink_hold <= 1'b1;
                repeat (300) @(posedge clk);
                sink_hold <= 1'b0;
            end
            offer_items(batch_q);
        join
        settle_block();
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        test_batch_limit();
        test_random_traffic();
        test_input_backpressure();

        settle_block();
        repeat (3) @(posedge clk);
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
